/* hdl/batch_fifo_ring_with_close_defines.svh */
// Assertion macros shared by the batch FIFO modules.
`ifndef BATCH_FIFO_RING_WITH_CLOSE_DEFINES_SVH
`define BATCH_FIFO_RING_WITH_CLOSE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define BFRC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BFRC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFRC_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define BFRC_ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

/* hdl/bfrc_pkg.sv */
// Shared types, codes and defaults of the batch FIFO.
package bfrc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [6:0] OFFSET_MAX = 7'd127;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_SPACE  = 3'd2;
  localparam logic [2:0] ST_DATA   = 3'd3;
  localparam logic [2:0] ST_SIZE   = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] push_value;
    logic        batch_end;
    logic [6:0]  pop_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pop_value;
    logic        run_last;
    logic        is_closed;
    logic [6:0]  occupancy;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic issue;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_go;
    logic last_issue;
  } stat_t;

endpackage

/* hdl/batch_fifo_ring_with_close.sv */
// Top level of the bounded batch FIFO with close latch.
// A push element is taken every cycle while busy is low; a batch end, a close or
// a failed pop answers with one result word the cycle after start. Results cannot
// be stalled. A good pop holds busy while it reads one slot RAM entry per value and
// streams one result word per value; the next word is taken once busy drops.
// Synchronous reset (rst_n low) empties and opens the queue and drops an open batch.
module batch_fifo_ring_with_close
  import bfrc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  // command/status between the controller and the datapath
  cmd_t  cmd;
  stat_t stat;

  // controller: start/busy handshake and pop read-out sequencing
  bfrc_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // datapath: pointers, staging, slot RAM and the result register
  bfrc_dp #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

endmodule

/* hdl/bfrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bfrc_ctrl.sv */
// Controller: accepts words and sequences the read-out of a batch pop.
`include "batch_fifo_ring_with_close_defines.svh"
module bfrc_ctrl
  import bfrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  assign cmd.accept = start && !busy_r;
  assign cmd.issue  = (state_r == S_POP);
  assign busy       = busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.pop_go) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.last_issue) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt == S_POP);
    end
  end

  `BFRC_ASSERT_RST(a_pop_ends, clk, rst_n, (state_r == S_POP && stat.last_issue) |=> !busy_r, "pop did not release busy")
  `BFRC_ASSERT_RST(a_busy_cause, clk, rst_n, $rose(busy_r) |-> $past(cmd.accept && stat.pop_go), "busy rose without a pop")

endmodule

/* hdl/bfrc_dp.sv */
// Datapath: ring pointers, batch staging, close flag, slot RAM, result register.
`include "batch_fifo_ring_with_close_defines.svh"
module bfrc_dp
  import bfrc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CPW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
    logic [IW:0] d;
    d = (s >= (IW+1)'(DEPTH)) ? s - (IW+1)'(DEPTH) : s;
    return d[IW-1:0];
  endfunction

  // queue state
  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            closed_r, closed_nxt;
  logic [6:0]      off_r, off_nxt;
  logic            spill_r, spill_nxt;
  // pop read-out
  logic [IW-1:0]   rdptr_r, rdptr_nxt;
  logic [CNTW-1:0] rem_r, rem_nxt;
  // result register
  logic            strobe_r, strobe_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            last_r, last_nxt;
  logic            rclosed_r, rclosed_nxt;
  logic [CNTW-1:0] occ_r, occ_nxt;
  logic            msel_r, msel_nxt;

  logic [7:0]  free8, off8, size8, cnt8;
  logic        fits, spill_eff, cnt_bad, cnt_short;
  logic        is_push, is_pop, is_close;
  logic        we;
  logic [IW-1:0]   waddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic [2:0]  push_st;

  assign is_push  = cmd.accept && (in_word.req_type == REQ_PUSH);
  assign is_pop   = cmd.accept && (in_word.req_type == REQ_POP);
  assign is_close = cmd.accept && (in_word.req_type == REQ_CLOSE);

  assign free8     = 8'(DEPTH) - 8'(count_r);
  assign off8      = {1'b0, off_r};
  assign size8     = off8 + 8'd1;
  assign cnt8      = {1'b0, in_word.pop_count};
  assign fits      = off8 < free8;
  assign spill_eff = spill_r || !fits;
  assign cnt_bad   = (cnt8 == 8'd0) || (cnt8 > 8'(DEPTH));
  assign cnt_short = cnt8 > 8'(count_r);

  assign stat.pop_go     = (in_word.req_type == REQ_POP) && !cnt_bad && !cnt_short;
  assign stat.last_issue = (rem_r == CNTW'(1));

  assign we    = is_push && fits;
  assign waddr = wrap((IW+1)'(tail_r) + (IW+1)'(off_r));
  assign wdata = VALUE_BITS'(in_word.push_value[CPW-1:0]);

  bfrc_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rdptr_r),
    .rdata(rdata)
  );

  always_comb begin
    if (size8 > 8'(DEPTH)) begin
      push_st = ST_SIZE;
    end else if (closed_r) begin
      push_st = ST_CLOSED;
    end else if (size8 > free8 || spill_eff) begin
      push_st = ST_SPACE;
    end else begin
      push_st = ST_OK;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    closed_nxt  = closed_r;
    off_nxt     = off_r;
    spill_nxt   = spill_r;
    rdptr_nxt   = rdptr_r;
    rem_nxt     = rem_r;
    strobe_nxt  = 1'b0;
    status_nxt  = ST_OK;
    last_nxt    = 1'b1;
    msel_nxt    = 1'b0;

    if (cmd.issue) begin
      rdptr_nxt  = (rdptr_r == IW'(DEPTH - 1)) ? '0 : rdptr_r + IW'(1);
      rem_nxt    = rem_r - CNTW'(1);
      strobe_nxt = 1'b1;
      last_nxt   = stat.last_issue;
      msel_nxt   = 1'b1;
    end else if (is_push) begin
      if (!in_word.batch_end) begin
        spill_nxt = spill_eff;
        off_nxt   = (off_r < OFFSET_MAX) ? off_r + 7'd1 : off_r;
      end else begin
        strobe_nxt = 1'b1;
        status_nxt = push_st;
        off_nxt    = '0;
        spill_nxt  = 1'b0;
        if (push_st == ST_OK) begin
          tail_nxt  = wrap((IW+1)'(tail_r) + (IW+1)'(size8));
          count_nxt = count_r + CNTW'(size8);
        end
      end
    end else if (is_pop) begin
      if (cnt_bad) begin
        strobe_nxt = 1'b1;
        status_nxt = ST_SIZE;
      end else if (cnt_short) begin
        strobe_nxt = 1'b1;
        status_nxt = ST_DATA;
      end else begin
        head_nxt  = wrap((IW+1)'(head_r) + (IW+1)'(in_word.pop_count));
        count_nxt = count_r - CNTW'(in_word.pop_count);
        rdptr_nxt = head_r;
        rem_nxt   = CNTW'(in_word.pop_count);
      end
    end else if (is_close) begin
      closed_nxt = 1'b1;
      strobe_nxt = 1'b1;
    end

    rclosed_nxt = closed_nxt;
    occ_nxt     = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      closed_r <= 1'b0;
      off_r    <= '0;
      spill_r  <= 1'b0;
      rdptr_r  <= '0;
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      closed_r <= closed_nxt;
      off_r    <= off_nxt;
      spill_r  <= spill_nxt;
      rdptr_r  <= rdptr_nxt;
      rem_r    <= rem_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    last_r    <= last_nxt;
    rclosed_r <= rclosed_nxt;
    occ_r     <= occ_nxt;
    msel_r    <= msel_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_word.status    = status_r;
  assign out_word.pop_value = msel_r ? 32'(rdata[CPW-1:0]) : 32'd0;
  assign out_word.run_last  = last_r;
  assign out_word.is_closed = rclosed_r;
  assign out_word.occupancy = 7'(occ_r);

  // head + count must land on tail
  logic [IW:0] hc_sum;
  assign hc_sum = (IW+1)'(head_r) + (IW+1)'(count_r);

  `BFRC_ASSERT_ALL(a_count_max, clk, !rst_n || count_r <= CNTW'(DEPTH), "occupancy above depth")
  `BFRC_ASSERT_RST(a_ring_sync, clk, rst_n, wrap(hc_sum) == tail_r, "head, tail and count disagree")
  `BFRC_ASSERT_RST(a_issue_rem, clk, rst_n, cmd.issue |-> rem_r != '0, "read issued with nothing left")

endmodule
